### rtl/dnsx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsx_pkg
// Shared types and constants for the DNS AAAA answer extractor.
// ----------------------------------------------------------------------------
package dnsx_pkg;

    localparam logic [7:0]  MAX_NAME_CHARS = 8'd255;
    localparam logic [15:0] TYPE_AAAA      = 16'd28;
    localparam logic [7:0]  DOT_CHAR       = 8'h2E;
    localparam logic [15:0] POS_SAT        = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ANSWER = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  name_char;
        logic [15:0] msg_id;
        logic [15:0] answer_count;
        logic [15:0] answer_type;
        logic [31:0] ttl;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        t_status     status;
        logic        end_mark;
    } t_result;

endpackage
`default_nettype wire

### rtl/dnsx_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsx_in_reg
// Input register: holds one message byte until the parser takes it.
// ----------------------------------------------------------------------------
module dnsx_in_reg (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  dnsx_pkg::t_item i_item,
    input  wire            i_take,
    output logic           o_valid,
    output dnsx_pkg::t_item o_item
);
    import dnsx_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

### rtl/dnsx_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsx_parse
// Per-message parse state: header capture, name decode, answer capture and
// end-of-message summary. State advances once per item taken.
// ----------------------------------------------------------------------------
module dnsx_parse (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [15:0]       i_cfg_data,
    input  wire              i_fire,
    input  dnsx_pkg::t_item  i_item,
    output logic             o_res_valid,
    output dnsx_pkg::t_result o_res
);
    import dnsx_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LEN    = 2'd1,
        PH_LABEL  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    logic [15:0] r_wanted;
    logic [15:0] r_pos,    n_pos;
    t_phase      r_phase,  n_phase;
    logic [7:0]  r_left,   n_left;
    logic        r_first,  n_first;
    logic [15:0] r_end,    n_end;
    logic [7:0]  r_count,  n_count;
    logic        r_long,   n_long;
    logic [15:0] r_id,     n_id;
    logic [15:0] r_ancnt,  n_ancnt;
    logic [15:0] r_type,   n_type;
    logic [31:0] r_ttl,    n_ttl;
    logic [63:0] r_ahi,    n_ahi;
    logic [63:0] r_alo,    n_alo;

    logic        emit_req;
    logic [7:0]  emit_c;
    logic        emit_ok;
    logic [15:0] rel;
    logic [16:0] eff;
    logic [16:0] end8;
    logic [16:0] end32;
    t_status     st;
    logic [7:0]  b;

    assign b = i_item.msg_byte;

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_left  = r_left;
        n_first = r_first;
        n_end   = r_end;
        n_count = r_count;
        n_long  = r_long;
        n_id    = r_id;
        n_ancnt = r_ancnt;
        n_type  = r_type;
        n_ttl   = r_ttl;
        n_ahi   = r_ahi;
        n_alo   = r_alo;
        emit_req = 1'b0;
        emit_c   = 8'd0;
        rel      = r_pos - r_end;

        case (r_phase)
            PH_HEADER: begin
                if (r_pos == 16'd0 || r_pos == 16'd1) begin
                    n_id = {r_id[7:0], b};
                end else if (r_pos == 16'd6 || r_pos == 16'd7) begin
                    n_ancnt = {r_ancnt[7:0], b};
                end
                if (r_pos >= 16'd11) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (b == 8'd0) begin
                    n_end   = r_pos;
                    n_phase = PH_DONE;
                end else begin
                    n_left  = b;
                    n_phase = PH_LABEL;
                    if (!r_first) begin
                        emit_req = 1'b1;
                        emit_c   = DOT_CHAR;
                    end
                    n_first = 1'b0;
                end
            end
            PH_LABEL: begin
                emit_req = 1'b1;
                emit_c   = b;
                n_left   = r_left - 8'd1;
                if (n_left == 8'd0) begin
                    n_phase = PH_LEN;
                end
            end
            default: begin
                if (r_pos != POS_SAT) begin
                    if (rel == 16'd7 || rel == 16'd8) begin
                        n_type = {r_type[7:0], b};
                    end else if (rel >= 16'd11 && rel <= 16'd14) begin
                        n_ttl = {r_ttl[23:0], b};
                    end else if (rel >= 16'd17 && rel <= 16'd24) begin
                        n_ahi = {r_ahi[55:0], b};
                    end else if (rel >= 16'd25 && rel <= 16'd32) begin
                        n_alo = {r_alo[55:0], b};
                    end
                end
            end
        endcase

        emit_ok = emit_req && (r_count < MAX_NAME_CHARS);
        if (emit_req && !emit_ok) begin
            n_long = 1'b1;
        end
        if (emit_ok) begin
            n_count = r_count + 8'd1;
        end

        if (r_pos != POS_SAT) begin
            n_pos = r_pos + 16'd1;
        end

        // summary status from the state after this byte
        eff   = (r_pos == POS_SAT) ? {1'b0, POS_SAT - 16'd1} : {1'b0, r_pos};
        end8  = {1'b0, n_end} + 17'd8;
        end32 = {1'b0, n_end} + 17'd32;
        if (n_phase != PH_DONE || n_long) begin
            st = ST_MALFORMED;
        end else if (n_ancnt == 16'd0) begin
            st = ST_NO_ANSWER;
        end else if (eff < end8) begin
            st = ST_MALFORMED;
        end else if (n_type != r_wanted) begin
            st = ST_MISMATCH;
        end else if (eff < end32) begin
            st = ST_MALFORMED;
        end else begin
            st = ST_OK;
        end

        o_res       = '0;
        o_res_valid = 1'b0;
        if (i_item.last_byte) begin
            o_res_valid        = 1'b1;
            o_res.out_kind     = 1'b1;
            o_res.msg_id       = n_id;
            o_res.answer_count = n_ancnt;
            o_res.answer_type  = n_type;
            o_res.ttl          = n_ttl;
            o_res.addr_high    = n_ahi;
            o_res.addr_low     = n_alo;
            o_res.status       = st;
            o_res.end_mark     = 1'b1;
            n_pos   = 16'd0;
            n_phase = PH_HEADER;
            n_left  = 8'd0;
            n_first = 1'b1;
            n_end   = 16'd0;
            n_count = 8'd0;
            n_long  = 1'b0;
            n_id    = 16'd0;
            n_ancnt = 16'd0;
            n_type  = 16'd0;
            n_ttl   = 32'd0;
            n_ahi   = 64'd0;
            n_alo   = 64'd0;
        end else if (emit_ok) begin
            o_res_valid     = 1'b1;
            o_res.name_char = emit_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= TYPE_AAAA;
        end else if (i_cfg_we) begin
            r_wanted <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 16'd0;
            r_phase <= PH_HEADER;
            r_left  <= 8'd0;
            r_first <= 1'b1;
            r_end   <= 16'd0;
            r_count <= 8'd0;
            r_long  <= 1'b0;
            r_id    <= 16'd0;
            r_ancnt <= 16'd0;
            r_type  <= 16'd0;
            r_ttl   <= 32'd0;
            r_ahi   <= 64'd0;
            r_alo   <= 64'd0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_first <= n_first;
            r_end   <= n_end;
            r_count <= n_count;
            r_long  <= n_long;
            r_id    <= n_id;
            r_ancnt <= n_ancnt;
            r_type  <= n_type;
            r_ttl   <= n_ttl;
            r_ahi   <= n_ahi;
            r_alo   <= n_alo;
        end
    end

endmodule
`default_nettype wire

### rtl/dnsx_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsx_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module dnsx_out_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  wire               i_load_valid,
    input  dnsx_pkg::t_result i_res,
    input  wire               i_ready,
    output logic              o_free,
    output logic              o_valid,
    output dnsx_pkg::t_result o_res
);
    import dnsx_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_load_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_load_valid) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

### rtl/dns_aaaa_answer_extractor.sv
`default_nettype none
// A result item passes from the input register through the combinational
// parser into the result register.
// Throughput: one byte per cycle when not stalled; the parse state updates in a single step.
// A stalled result register holds the parser and the input register.
// Reset (synchronous, active low) clears all message state and sets the
// wanted type to 28.
// ----------------------------------------------------------------------------
// dns_aaaa_answer_extractor
// Parses a DNS response byte stream, streams the question name and reports
// the first answer's type, TTL and address with a status.
// ----------------------------------------------------------------------------
module dns_aaaa_answer_extractor (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_msg_byte,
    input  wire         i_last_byte,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_data,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_name_char,
    output logic [15:0] o_msg_id,
    output logic [15:0] o_answer_count,
    output logic [15:0] o_answer_type,
    output logic [31:0] o_ttl,
    output logic [63:0] o_addr_high,
    output logic [63:0] o_addr_low,
    output logic [1:0]  o_status,
    output logic        o_end_mark
);
    import dnsx_pkg::*;

    t_item   in_item;
    t_item   q_item;
    logic    q_valid;
    logic    fire;
    logic    out_free;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.msg_byte  = i_msg_byte;
    assign in_item.last_byte = i_last_byte;
    assign fire = q_valid && out_free;

    dnsx_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    dnsx_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (q_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dnsx_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (fire),
        .i_load_valid (res_valid),
        .i_res        (res),
        .i_ready      (i_ready),
        .o_free       (out_free),
        .o_valid      (o_valid),
        .o_res        (out_res)
    );

    assign o_out_kind     = out_res.out_kind;
    assign o_name_char    = out_res.name_char;
    assign o_msg_id       = out_res.msg_id;
    assign o_answer_count = out_res.answer_count;
    assign o_answer_type  = out_res.answer_type;
    assign o_ttl          = out_res.ttl;
    assign o_addr_high    = out_res.addr_high;
    assign o_addr_low     = out_res.addr_low;
    assign o_status       = out_res.status;
    assign o_end_mark     = out_res.end_mark;

    a_summary_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_kind == o_end_mark))
        else $error("end mark does not follow item kind");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_kind) |-> (o_msg_id == 16'd0 && o_status == ST_OK))
        else $error("name character item carries summary fields");

    a_ok_has_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_kind && o_status == ST_OK) |-> (o_answer_count != 16'd0))
        else $error("ok status with no answers");

    a_no_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_kind && o_status == ST_NO_ANSWER) |-> (o_answer_count == 16'd0))
        else $error("no-answer status with answers present");

endmodule
`default_nettype wire
